// ===== sv/rqs_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package rqs_pkg;

	localparam int ENTRIES = 8;
	localparam int IDX_W   = $clog2(ENTRIES);
	localparam int CNT_W   = $clog2(ENTRIES + 1);
	localparam int MAX_RES = 16;
	localparam int ECNT_W  = $clog2(MAX_RES + 1);

	localparam logic [1:0] OP_ENQ  = 2'd0;
	localparam logic [1:0] OP_ACK  = 2'd1;
	localparam logic [1:0] OP_TICK = 2'd2;
	localparam logic [1:0] OP_SEND = 2'd3;

	localparam logic [1:0] KIND_ENQ  = 2'd0;
	localparam logic [1:0] KIND_ACK  = 2'd1;
	localparam logic [1:0] KIND_TX   = 2'd2;
	localparam logic [1:0] KIND_DONE = 2'd3;

	localparam logic QSEL_WAIT  = 1'b0;
	localparam logic QSEL_READY = 1'b1;

	typedef enum logic [3:0] {
		DP_NOP,
		DP_LATCH,
		DP_ENQ,
		DP_DIRECT,
		DP_IDX_CLR,
		DP_W_STEP,
		DP_R_STEP,
		DP_S_SEND,
		DP_S_MOVE,
		DP_A_NEXT,
		DP_A_FIN,
		DP_A_REP,
		DP_A_NONE,
		DP_FLUSH
	} dp_op_t;

	typedef struct packed {
		dp_op_t op;
		logic   qsel;
	} dp_cmd_t;

	typedef struct packed {
		logic [1:0] op;
		logic       lt;
		logic       match;
		logic       emit_ok;
		logic       flush_ok;
		logic       pend_v;
		logic       both_empty;
		logic       rcnt_zero;
	} dp_stat_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic        ok;
		logic [7:0]  tx_byte;
		logic [15:0] seq_num;
		logic [3:0]  tag_out;
		logic        outcome;
		logic        last;
	} res_t;

endpackage
`default_nettype wire

// ===== sv/rqs_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
interface rqs_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  op;
	logic [7:0]  char_code;
	logic [7:0]  retries;
	logic [15:0] wait_ticks;
	logic [3:0]  owner_tag;
	logic        ack_outcome;
	logic [7:0]  uart_space;
	modport source(output valid, op, char_code, retries, wait_ticks, owner_tag,
		ack_outcome, uart_space, input ready);
	modport sink(input valid, op, char_code, retries, wait_ticks, owner_tag,
		ack_outcome, uart_space, output ready);
endinterface

interface rqs_rsp_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic        ok;
	logic [7:0]  tx_byte;
	logic [15:0] seq_num;
	logic [3:0]  tag_out;
	logic        outcome;
	logic        last;
	modport source(output valid, kind, ok, tx_byte, seq_num, tag_out, outcome, last,
		input ready);
	modport sink(input valid, kind, ok, tx_byte, seq_num, tag_out, outcome, last,
		output ready);
endinterface
`default_nettype wire

// ===== sv/rqs_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none
module rqs_datapath import rqs_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire dp_cmd_t     cmd,
	input  wire logic [1:0]  op,
	input  wire logic [7:0]  char_code,
	input  wire logic [7:0]  retries,
	input  wire logic [15:0] wait_ticks,
	input  wire logic [3:0]  owner_tag,
	input  wire logic        ack_outcome,
	input  wire logic [7:0]  uart_space,
	output dp_stat_t         stat,
	output logic             rsp_valid,
	input  wire logic        rsp_ready,
	output res_t             rsp_word
);

	logic [7:0]  byte_q [ENTRIES];
	logic [7:0]  ret_q  [ENTRIES];
	logic [15:0] ela_q  [ENTRIES];
	logic [15:0] wai_q  [ENTRIES];
	logic [15:0] seq_q  [ENTRIES];
	logic [3:0]  tag_q  [ENTRIES];
	logic [IDX_W-1:0] wq_q [ENTRIES];
	logic [IDX_W-1:0] rq_q [ENTRIES];
	logic [IDX_W-1:0] wq_n [ENTRIES];
	logic [IDX_W-1:0] rq_n [ENTRIES];
	logic [CNT_W-1:0] wcnt_q, rcnt_q, wcnt_n, rcnt_n, cnt_sel, idx_q;
	logic [ENTRIES-1:0] free_q;
	logic [15:0] nseq_q;
	logic [1:0]  op_q;
	logic [7:0]  ch_q, rt_q, sp_q;
	logic [15:0] wt_q;
	logic [3:0]  tg_q;
	logic        ao_q;
	logic [IDX_W-1:0] hold_q, cur_e, ent, fe;
	logic        ffound;
	logic [ECNT_W-1:0] ecnt_q;
	logic        pv_q, ov_q;
	res_t        pend_q, out_q, em;
	logic        em_v, flush_ok, emit_ok, tmo;
	logic [15:0] ela1;
	logic [7:0]  ret_cur, retm1;
	logic        rm_w, rm_r, ap_w, ap_r;
	logic [IDX_W-1:0] ap_val;

	assign cnt_sel  = cmd.qsel ? rcnt_q : wcnt_q;
	assign cur_e    = cmd.qsel ? rq_q[idx_q[IDX_W-1:0]] : wq_q[idx_q[IDX_W-1:0]];
	assign ent      = (cmd.op == DP_A_REP) ? hold_q : cur_e;
	assign ela1     = ela_q[cur_e] + 16'd1;
	assign tmo      = ela1 > wai_q[cur_e];
	assign ret_cur  = ret_q[cur_e];
	assign retm1    = ret_cur - 8'd1;
	assign flush_ok = !ov_q || rsp_ready;
	assign emit_ok  = !pv_q || flush_ok;

	always_comb begin
		fe = '0;
		ffound = 1'b0;
		for (int i = 0; i < ENTRIES; i++) begin
			if (free_q[i] && !ffound) begin
				fe = IDX_W'(i);
				ffound = 1'b1;
			end
		end
	end

	assign stat.op         = op_q;
	assign stat.lt         = idx_q < cnt_sel;
	assign stat.match      = (byte_q[cur_e] == ch_q) && (ret_cur != 8'd0);
	assign stat.emit_ok    = emit_ok;
	assign stat.flush_ok   = flush_ok;
	assign stat.pend_v     = pv_q;
	assign stat.both_empty = (wcnt_q == '0) && (rcnt_q == '0);
	assign stat.rcnt_zero  = rcnt_q == '0;

	always_comb begin
		em_v = 1'b0;
		em = '0;
		unique case (cmd.op)
			DP_ENQ: begin
				em_v = 1'b1;
				em.kind = KIND_ENQ;
				em.ok = ffound;
				em.tx_byte = ffound ? ch_q : 8'd0;
				em.seq_num = ffound ? nseq_q : 16'd0;
			end
			DP_DIRECT: begin
				em_v = 1'b1;
				em.kind = KIND_TX;
				em.tx_byte = ch_q;
			end
			DP_W_STEP: begin
				em_v = tmo && (retm1 == 8'd0);
				em.kind = KIND_DONE;
				em.outcome = 1'b1;
			end
			DP_R_STEP: begin
				em_v = tmo && (ret_cur == 8'd0);
				em.kind = KIND_DONE;
				em.outcome = 1'b1;
			end
			DP_S_SEND: begin
				em_v = sp_q != 8'd0;
				em.kind = KIND_TX;
			end
			DP_S_MOVE: begin
				em_v = ret_cur == 8'd0;
				em.kind = KIND_DONE;
			end
			DP_A_FIN: begin
				em_v = 1'b1;
				em.kind = KIND_DONE;
				em.outcome = ao_q;
			end
			DP_A_REP: begin
				em_v = 1'b1;
				em.kind = KIND_ACK;
				em.ok = 1'b1;
			end
			DP_A_NONE: begin
				em_v = 1'b1;
				em.kind = KIND_ACK;
			end
			default: em_v = 1'b0;
		endcase
		if (cmd.op == DP_W_STEP || cmd.op == DP_R_STEP || cmd.op == DP_S_SEND ||
			cmd.op == DP_S_MOVE || cmd.op == DP_A_FIN || cmd.op == DP_A_REP) begin
			em.tx_byte = byte_q[ent];
			em.seq_num = seq_q[ent];
		end
		if (cmd.op == DP_W_STEP || cmd.op == DP_R_STEP || cmd.op == DP_S_MOVE ||
			cmd.op == DP_A_FIN) begin
			em.tag_out = tag_q[ent];
		end
	end

	always_comb begin
		rm_w = 1'b0;
		rm_r = 1'b0;
		ap_w = 1'b0;
		ap_r = 1'b0;
		ap_val = cur_e;
		unique case (cmd.op)
			DP_W_STEP: begin
				rm_w = tmo;
				ap_r = tmo && (retm1 != 8'd0);
			end
			DP_R_STEP: rm_r = tmo && (ret_cur == 8'd0);
			DP_S_MOVE: begin
				rm_r = 1'b1;
				ap_w = ret_cur != 8'd0;
			end
			DP_A_FIN: begin
				rm_r = cmd.qsel;
				rm_w = !cmd.qsel;
			end
			DP_ENQ: begin
				ap_r = ffound;
				ap_val = fe;
			end
			default: rm_w = 1'b0;
		endcase
		wq_n = wq_q;
		rq_n = rq_q;
		wcnt_n = wcnt_q;
		rcnt_n = rcnt_q;
		if (rm_w) begin
			for (int i = 0; i < ENTRIES - 1; i++) begin
				if (i >= int'(idx_q)) wq_n[i] = wq_q[i + 1];
			end
			wcnt_n = wcnt_q - 1'b1;
		end
		if (rm_r) begin
			for (int i = 0; i < ENTRIES - 1; i++) begin
				if (i >= int'(idx_q)) rq_n[i] = rq_q[i + 1];
			end
			rcnt_n = rcnt_q - 1'b1;
		end
		if (ap_w && wcnt_n < CNT_W'(ENTRIES)) begin
			wq_n[wcnt_n[IDX_W-1:0]] = ap_val;
			wcnt_n = wcnt_n + 1'b1;
		end
		if (ap_r && rcnt_n < CNT_W'(ENTRIES)) begin
			rq_n[rcnt_n[IDX_W-1:0]] = ap_val;
			rcnt_n = rcnt_n + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wcnt_q <= '0;
			rcnt_q <= '0;
			free_q <= '1;
			nseq_q <= '0;
			idx_q  <= '0;
			ecnt_q <= '0;
			pv_q   <= 1'b0;
			ov_q   <= 1'b0;
		end else begin
			wcnt_q <= wcnt_n;
			rcnt_q <= rcnt_n;
			unique case (cmd.op)
				DP_LATCH, DP_IDX_CLR: idx_q <= '0;
				DP_W_STEP: if (!tmo) idx_q <= idx_q + 1'b1;
				DP_R_STEP: if (!(tmo && ret_cur == 8'd0)) idx_q <= idx_q + 1'b1;
				DP_A_NEXT: idx_q <= idx_q + 1'b1;
				default: idx_q <= idx_q;
			endcase
			if (cmd.op == DP_LATCH) ecnt_q <= '0;
			if (cmd.op == DP_ENQ && ffound) begin
				free_q[fe] <= 1'b0;
				nseq_q <= nseq_q + 16'd1;
			end
			if ((cmd.op == DP_W_STEP && tmo && retm1 == 8'd0) ||
				(cmd.op == DP_R_STEP && tmo && ret_cur == 8'd0) ||
				(cmd.op == DP_S_MOVE && ret_cur == 8'd0) || cmd.op == DP_A_FIN) begin
				free_q[cur_e] <= 1'b1;
			end
			if (em_v && ecnt_q < ECNT_W'(MAX_RES)) begin
				ecnt_q <= ecnt_q + 1'b1;
				pv_q <= 1'b1;
				if (pv_q) ov_q <= 1'b1;
				else if (rsp_ready) ov_q <= 1'b0;
			end else if (cmd.op == DP_FLUSH && pv_q) begin
				pv_q <= 1'b0;
				ov_q <= 1'b1;
			end else if (ov_q && rsp_ready) begin
				ov_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		wq_q <= wq_n;
		rq_q <= rq_n;
		if (em_v && ecnt_q < ECNT_W'(MAX_RES)) begin
			pend_q <= em;
			if (pv_q) out_q <= pend_q;
		end else if (cmd.op == DP_FLUSH && pv_q) begin
			out_q <= {pend_q[$bits(res_t)-1:1], 1'b1};
		end
		unique case (cmd.op)
			DP_LATCH: begin
				op_q <= op;
				ch_q <= char_code;
				rt_q <= retries;
				wt_q <= wait_ticks;
				tg_q <= owner_tag;
				ao_q <= ack_outcome;
				sp_q <= uart_space;
			end
			DP_ENQ: if (ffound) begin
				byte_q[fe] <= ch_q;
				seq_q[fe]  <= nseq_q;
				ret_q[fe]  <= rt_q;
				wai_q[fe]  <= wt_q;
				ela_q[fe]  <= 16'd0;
				tag_q[fe]  <= tg_q;
			end
			DP_W_STEP: begin
				if (tmo) begin
					ela_q[cur_e] <= 16'd0;
					ret_q[cur_e] <= retm1;
				end else begin
					ela_q[cur_e] <= ela1;
				end
			end
			DP_R_STEP: begin
				if (tmo) begin
					ela_q[cur_e] <= 16'd0;
					if (ret_cur != 8'd0) ret_q[cur_e] <= retm1;
				end else begin
					ela_q[cur_e] <= ela1;
				end
			end
			DP_S_SEND: if (sp_q != 8'd0) sp_q <= sp_q - 8'd1;
			DP_S_MOVE: if (ret_cur != 8'd0) ela_q[cur_e] <= 16'd0;
			DP_A_FIN: hold_q <= cur_e;
			default: hold_q <= hold_q;
		endcase
	end

	assign rsp_valid = ov_q;
	assign rsp_word  = out_q;

endmodule
`default_nettype wire

// ===== sv/rqs_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
module rqs_ctrl import rqs_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     req_valid,
	output logic          req_ready,
	input  wire dp_stat_t stat,
	output dp_cmd_t       cmd
);

	typedef enum logic [9:0] {
		S_IDLE  = 10'b0000000001,
		S_DISP  = 10'b0000000010,
		S_WAGE  = 10'b0000000100,
		S_RAGE  = 10'b0000001000,
		S_SEND  = 10'b0000010000,
		S_MOVE  = 10'b0000100000,
		S_ASW   = 10'b0001000000,
		S_ASR   = 10'b0010000000,
		S_AREP  = 10'b0100000000,
		S_FLUSH = 10'b1000000000
	} state_t;

	state_t state_q, state_n;

	assign req_ready = state_q == S_IDLE;

	always_comb begin
		state_n = state_q;
		cmd.op = DP_NOP;
		cmd.qsel = QSEL_WAIT;
		unique case (state_q)
			S_IDLE: if (req_valid) begin
				cmd.op = DP_LATCH;
				state_n = S_DISP;
			end
			S_DISP: begin
				unique case (stat.op)
					OP_ENQ: if (stat.emit_ok) begin
						cmd.op = DP_ENQ;
						state_n = S_FLUSH;
					end
					OP_SEND: if (stat.emit_ok) begin
						cmd.op = DP_DIRECT;
						state_n = S_FLUSH;
					end
					OP_ACK: state_n = S_ASW;
					default: state_n = stat.both_empty ? S_FLUSH : S_WAGE;
				endcase
			end
			S_WAGE: begin
				if (!stat.lt) begin
					cmd.op = DP_IDX_CLR;
					state_n = S_RAGE;
				end else if (stat.emit_ok) begin
					cmd.op = DP_W_STEP;
				end
			end
			S_RAGE: begin
				cmd.qsel = QSEL_READY;
				if (!stat.lt) begin
					cmd.op = DP_IDX_CLR;
					state_n = S_SEND;
				end else if (stat.emit_ok) begin
					cmd.op = DP_R_STEP;
				end
			end
			S_SEND: begin
				cmd.qsel = QSEL_READY;
				if (stat.rcnt_zero) begin
					state_n = S_FLUSH;
				end else if (stat.emit_ok) begin
					cmd.op = DP_S_SEND;
					state_n = S_MOVE;
				end
			end
			S_MOVE: begin
				cmd.qsel = QSEL_READY;
				if (stat.emit_ok) begin
					cmd.op = DP_S_MOVE;
					state_n = S_SEND;
				end
			end
			S_ASW: begin
				if (!stat.lt) begin
					cmd.op = DP_IDX_CLR;
					state_n = S_ASR;
				end else if (stat.match) begin
					if (stat.emit_ok) begin
						cmd.op = DP_A_FIN;
						state_n = S_AREP;
					end
				end else begin
					cmd.op = DP_A_NEXT;
				end
			end
			S_ASR: begin
				cmd.qsel = QSEL_READY;
				if (!stat.lt) begin
					if (stat.emit_ok) begin
						cmd.op = DP_A_NONE;
						state_n = S_FLUSH;
					end
				end else if (stat.match) begin
					if (stat.emit_ok) begin
						cmd.op = DP_A_FIN;
						state_n = S_AREP;
					end
				end else begin
					cmd.op = DP_A_NEXT;
				end
			end
			S_AREP: if (stat.emit_ok) begin
				cmd.op = DP_A_REP;
				state_n = S_FLUSH;
			end
			S_FLUSH: begin
				if (!stat.pend_v) begin
					state_n = S_IDLE;
				end else if (stat.flush_ok) begin
					cmd.op = DP_FLUSH;
					state_n = S_IDLE;
				end
			end
			default: state_n = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

endmodule
`default_nettype wire

// ===== sv/retransmit_queue_scheduler.sv =====
// Resend scheduler for single control bytes over a pool of eight entries.
// req (sink): one command word per handshake; op selects enqueue,
// acknowledge, 1 ms tick or direct byte send, the other fields go with it.
// rsp (source): result words, each with kind, ok, byte, sequence number,
// tag and outcome; last marks the final word of a command. A tick with both
// queues empty gives no word. At most 16 words per command.
// One command at a time: req.ready is high only while the block is idle.
// Enqueue and direct send each give a single word, which passes the hold
// stage and the output register before it reaches rsp.
// Acknowledge scans the waiting queue, then the ready queue, for a match.
// A tick ages the waiting entries, then the ready entries, then sends each
// ready entry while space lasts and moves it back to waiting or retires it.
// Words pass through a one-word hold stage and an output register; when the
// receiver stalls, the sequencer halts until a slot opens, no word is lost.
// Reset empties both queues, frees every entry and clears the sequence
// counter; the block is ready on the first cycle after reset.
`timescale 1ns / 1ps
`default_nettype none
module retransmit_queue_scheduler import rqs_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	rqs_req_if.sink  req,
	rqs_rsp_if.source rsp
);

	dp_cmd_t  cmd;
	dp_stat_t stat;
	res_t     word;

	rqs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	rqs_datapath u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.op          (req.op),
		.char_code   (req.char_code),
		.retries     (req.retries),
		.wait_ticks  (req.wait_ticks),
		.owner_tag   (req.owner_tag),
		.ack_outcome (req.ack_outcome),
		.uart_space  (req.uart_space),
		.stat        (stat),
		.rsp_valid   (rsp.valid),
		.rsp_ready   (rsp.ready),
		.rsp_word    (word)
	);

	assign rsp.kind    = word.kind;
	assign rsp.ok      = word.ok;
	assign rsp.tx_byte = word.tx_byte;
	assign rsp.seq_num = word.seq_num;
	assign rsp.tag_out = word.tag_out;
	assign rsp.outcome = word.outcome;
	assign rsp.last    = word.last;

endmodule
`default_nettype wire

// ===== bench/tb_retransmit_queue_scheduler.sv =====
`timescale 1ns / 1ps
module tb_retransmit_queue_scheduler;
	import rqs_pkg::*;

	typedef struct packed {
		logic [1:0]  op;
		logic [7:0]  char_code;
		logic [7:0]  retries;
		logic [15:0] wait_ticks;
		logic [3:0]  owner_tag;
		logic        ack_outcome;
		logic [7:0]  uart_space;
	} cmd_t;

	logic clk;
	logic arst_n;

	rqs_req_if req();
	rqs_rsp_if rsp();

	retransmit_queue_scheduler i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req),
		.rsp(rsp)
	);

	cmd_t pending_cmds[$];
	res_t expected_words[$];
	int errors = 0;
	int cmds_sent = 0;
	int words_seen = 0;
	bit stim_done = 0;
	int hold_off = 0;
	int send_gap = 0;
	int recv_gap = 0;

	logic [7:0]  sc_byte[ENTRIES];
	logic [7:0]  sc_retries[ENTRIES];
	logic [15:0] sc_elapsed[ENTRIES];
	logic [15:0] sc_wait[ENTRIES];
	logic [15:0] sc_seq[ENTRIES];
	logic [3:0]  sc_tag[ENTRIES];
	int          wait_q[$];
	int          ready_q[$];
	logic [ENTRIES-1:0] free_map;
	logic [15:0] seq_counter;
	int          word_cnt;

	function automatic int gap_len();
		if ($urandom_range(0, 19) == 0)
			return $urandom_range(10, 40);
		if ($urandom_range(0, 2) == 0)
			return $urandom_range(1, 3);
		return 0;
	endfunction

	function automatic void push_word(logic [1:0] kind, logic ok, logic [7:0] b,
		logic [15:0] s, logic [3:0] tg, logic oc);
		res_t r;
		if (word_cnt >= MAX_RES)
			return;
		r.kind = kind;
		r.ok = ok;
		r.tx_byte = b;
		r.seq_num = s;
		r.tag_out = tg;
		r.outcome = oc;
		r.last = 1'b0;
		expected_words.push_back(r);
		word_cnt++;
	endfunction

	function automatic void retire_entry(int e, logic oc);
		free_map[e] = 1'b1;
		push_word(KIND_DONE, 1'b0, sc_byte[e], sc_seq[e], sc_tag[e], oc);
	endfunction

	function automatic bit ack_scan(bit in_wait, logic [7:0] ch, logic oc);
		int e;
		int n;
		n = in_wait ? wait_q.size() : ready_q.size();
		for (int i = 0; i < n; i++) begin
			e = in_wait ? wait_q[i] : ready_q[i];
			if (sc_byte[e] == ch && sc_retries[e] != 0) begin
				if (in_wait)
					wait_q.delete(i);
				else
					ready_q.delete(i);
				retire_entry(e, oc);
				push_word(KIND_ACK, 1'b1, sc_byte[e], sc_seq[e], 4'd0, 1'b0);
				return 1;
			end
		end
		return 0;
	endfunction

	task automatic run_tick(logic [7:0] space_in);
		int i;
		int e;
		int space;
		space = space_in;
		if (wait_q.size() + ready_q.size() == 0)
			return;
		i = 0;
		while (i < wait_q.size()) begin
			e = wait_q[i];
			sc_elapsed[e] = sc_elapsed[e] + 16'd1;
			if (sc_elapsed[e] > sc_wait[e]) begin
				sc_elapsed[e] = '0;
				wait_q.delete(i);
				sc_retries[e] = sc_retries[e] - 8'd1;
				if (sc_retries[e] == 0)
					retire_entry(e, 1'b1);
				else
					ready_q.push_back(e);
			end else begin
				i++;
			end
		end
		i = 0;
		while (i < ready_q.size()) begin
			e = ready_q[i];
			sc_elapsed[e] = sc_elapsed[e] + 16'd1;
			if (sc_elapsed[e] > sc_wait[e]) begin
				sc_elapsed[e] = '0;
				if (sc_retries[e] == 0) begin
					ready_q.delete(i);
					retire_entry(e, 1'b1);
					continue;
				end
				sc_retries[e] = sc_retries[e] - 8'd1;
			end
			i++;
		end
		while (ready_q.size() > 0) begin
			e = ready_q.pop_front();
			if (space >= 1) begin
				push_word(KIND_TX, 1'b0, sc_byte[e], sc_seq[e], 4'd0, 1'b0);
				space--;
			end
			if (sc_retries[e] > 0) begin
				sc_elapsed[e] = '0;
				wait_q.push_back(e);
			end else begin
				retire_entry(e, 1'b0);
			end
		end
	endtask

	task automatic predict_cmd(cmd_t c);
		int e;
		int base;
		base = expected_words.size();
		word_cnt = 0;
		case (c.op)
			OP_ENQ: begin
				e = -1;
				for (int k = 0; k < ENTRIES; k++)
					if (e < 0 && free_map[k])
						e = k;
				if (e < 0) begin
					push_word(KIND_ENQ, 1'b0, 8'd0, 16'd0, 4'd0, 1'b0);
				end else begin
					free_map[e] = 1'b0;
					sc_byte[e] = c.char_code;
					sc_seq[e] = seq_counter;
					seq_counter = seq_counter + 16'd1;
					sc_retries[e] = c.retries;
					sc_wait[e] = c.wait_ticks;
					sc_elapsed[e] = '0;
					sc_tag[e] = c.owner_tag;
					ready_q.push_back(e);
					push_word(KIND_ENQ, 1'b1, c.char_code, sc_seq[e], 4'd0, 1'b0);
				end
			end
			OP_ACK: begin
				if (!ack_scan(1, c.char_code, c.ack_outcome) &&
					!ack_scan(0, c.char_code, c.ack_outcome))
					push_word(KIND_ACK, 1'b0, 8'd0, 16'd0, 4'd0, 1'b0);
			end
			OP_TICK: run_tick(c.uart_space);
			default: push_word(KIND_TX, 1'b0, c.char_code, 16'd0, 4'd0, 1'b0);
		endcase
		if (expected_words.size() > base)
			expected_words[expected_words.size() - 1].last = 1'b1;
	endtask

	function automatic cmd_t make_cmd(logic [1:0] op, logic [7:0] ch, logic [7:0] rt,
		logic [15:0] wt, logic [3:0] tg, logic ao, logic [7:0] sp);
		cmd_t c;
		c.op = op;
		c.char_code = ch;
		c.retries = rt;
		c.wait_ticks = wt;
		c.owner_tag = tg;
		c.ack_outcome = ao;
		c.uart_space = sp;
		return c;
	endfunction

	function automatic cmd_t rand_cmd();
		cmd_t c;
		int pick;
		c.owner_tag = 4'($urandom);
		c.ack_outcome = 1'($urandom);
		c.char_code = 8'($urandom_range(0, 7));
		if ($urandom_range(0, 9) == 0)
			c.char_code = 8'($urandom);
		pick = $urandom_range(0, 9);
		c.op = pick < 3 ? OP_ENQ : pick < 5 ? OP_ACK : pick < 9 ? OP_TICK : OP_SEND;
		c.retries = 8'($urandom_range(0, 9) == 0 ? $urandom : $urandom_range(0, 3));
		c.wait_ticks = 16'($urandom_range(0, 9) == 0 ? $urandom : $urandom_range(0, 3));
		c.uart_space = 8'($urandom_range(0, 4) == 0 ? $urandom_range(0, 2) : $urandom);
		return c;
	endfunction

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		arst_n = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
	end

	initial begin
		free_map = '1;
		seq_counter = '0;
		pending_cmds.push_back(make_cmd(OP_TICK, 8'h00, 8'h00, 16'h0000, 4'h0, 1'b0, 8'hff));
		pending_cmds.push_back(make_cmd(OP_ACK, 8'h55, 8'h00, 16'h0000, 4'h0, 1'b0, 8'h00));
		pending_cmds.push_back(make_cmd(OP_SEND, 8'hff, 8'hff, 16'hffff, 4'hf, 1'b1, 8'h00));
		pending_cmds.push_back(make_cmd(OP_SEND, 8'h00, 8'h00, 16'h0000, 4'h0, 1'b0, 8'hff));
		pending_cmds.push_back(make_cmd(OP_ENQ, 8'h00, 8'h00, 16'h0000, 4'h0, 1'b0, 8'h00));
		pending_cmds.push_back(make_cmd(OP_ENQ, 8'hff, 8'hff, 16'hffff, 4'hf, 1'b1, 8'hff));
		pending_cmds.push_back(make_cmd(OP_ENQ, 8'h11, 8'h01, 16'h0000, 4'h3, 1'b0, 8'h00));
		pending_cmds.push_back(make_cmd(OP_ENQ, 8'h22, 8'h02, 16'h0001, 4'h5, 1'b0, 8'h00));
		for (int k = 0; k < 5; k++)
			pending_cmds.push_back(make_cmd(OP_ENQ, 8'(8'h30 + k), 8'h01, 16'h0000, 4'(k),
				1'b0, 8'h00));
		pending_cmds.push_back(make_cmd(OP_ACK, 8'hff, 8'h00, 16'h0000, 4'h0, 1'b1, 8'h00));
		pending_cmds.push_back(make_cmd(OP_TICK, 8'h00, 8'h00, 16'h0000, 4'h0, 1'b0, 8'h00));
		pending_cmds.push_back(make_cmd(OP_TICK, 8'h00, 8'h00, 16'h0000, 4'h0, 1'b0, 8'h02));
		pending_cmds.push_back(make_cmd(OP_TICK, 8'h00, 8'h00, 16'h0000, 4'h0, 1'b0, 8'hff));
		pending_cmds.push_back(make_cmd(OP_ACK, 8'h22, 8'h00, 16'h0000, 4'h0, 1'b0, 8'h00));
		pending_cmds.push_back(make_cmd(OP_ACK, 8'h22, 8'h00, 16'h0000, 4'h0, 1'b1, 8'h00));
		for (int k = 0; k < 4; k++)
			pending_cmds.push_back(make_cmd(OP_TICK, 8'h00, 8'h00, 16'h0000, 4'h0, 1'b0,
				8'hff));
		for (int k = 0; k < 200; k++)
			pending_cmds.push_back(rand_cmd());
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req.valid <= 1'b0;
			req.op <= OP_ENQ;
			req.char_code <= '0;
			req.retries <= '0;
			req.wait_ticks <= '0;
			req.owner_tag <= '0;
			req.ack_outcome <= 1'b0;
			req.uart_space <= '0;
		end else begin
			if (req.valid && req.ready) begin
				predict_cmd({req.op, req.char_code, req.retries, req.wait_ticks,
					req.owner_tag, req.ack_outcome, req.uart_space});
				cmds_sent++;
			end
			if (!req.valid || req.ready) begin
				if (send_gap > 0) begin
					send_gap <= send_gap - 1;
					req.valid <= 1'b0;
				end else if (pending_cmds.size() > 0) begin
					cmd_t c;
					c = pending_cmds.pop_front();
					req.valid <= 1'b1;
					{req.op, req.char_code, req.retries, req.wait_ticks, req.owner_tag,
						req.ack_outcome, req.uart_space} <= c;
					send_gap <= gap_len();
				end else begin
					req.valid <= 1'b0;
					stim_done <= 1'b1;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp.ready <= 1'b0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				res_t got;
				res_t want;
				got = {rsp.kind, rsp.ok, rsp.tx_byte, rsp.seq_num, rsp.tag_out, rsp.outcome,
					rsp.last};
				words_seen++;
				if (expected_words.size() == 0) begin
					$display("%0t: unexpected word %h", $time, got);
					errors++;
				end else begin
					want = expected_words.pop_front();
					if (got !== want) begin
						$display("%0t: mismatch expected %h actual %h", $time, want, got);
						errors++;
					end
				end
			end
			if (cmds_sent == 40 && hold_off == 0)
				hold_off <= 300;
			if (hold_off > 1) begin
				hold_off <= hold_off - 1;
				rsp.ready <= 1'b0;
			end else if (recv_gap > 0) begin
				recv_gap <= recv_gap - 1;
				rsp.ready <= 1'b0;
			end else begin
				if (hold_off == 1)
					hold_off <= -1;
				rsp.ready <= 1'b1;
				recv_gap <= gap_len();
			end
		end
	end

	initial begin
		wait (stim_done);
		wait (expected_words.size() == 0);
		repeat (100) @(posedge clk);
		$display("Ran %0d commands, checked %0d result words against the scoreboard.",
			cmds_sent, words_seen);
		if (errors == 0 && expected_words.size() == 0)
			$display("PASS retransmit_queue_scheduler");
		else
			$display("FAIL retransmit_queue_scheduler");
		$finish;
	end

	initial begin
		#5ms;
		$display("FAIL retransmit_queue_scheduler");
		$finish;
	end
endmodule
